FILE: sv/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helpers for the JSON string unescape unit.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Result kinds carried on the result channel
    typedef enum logic [2:0] {
        ST_BYTE   = 3'd0,
        ST_CLOSED = 3'd1,
        ST_CTRL   = 3'd2,
        ST_BADESC = 3'd3,
        ST_BADHEX = 3'd4,
        ST_UNTERM = 3'd5
    } jsu_status_t;

    localparam int unsigned MaxResults = 4;
    localparam int unsigned SlotIdxW   = $clog2(MaxResults);
    localparam int unsigned CountW     = $clog2(MaxResults + 1);

    // Character constants
    localparam logic [7:0] ChQuote     = 8'h22;
    localparam logic [7:0] ChBackslash = 8'h5c;
    localparam logic [7:0] ChSlash     = 8'h2f;
    localparam logic [7:0] ChCtrlLimit = 8'h20;

    // UTF-8 encoding constants
    localparam logic [15:0] CpOneByteMax = 16'h007f;
    localparam logic [15:0] CpTwoByteMax = 16'h07ff;
    localparam logic [7:0]  Utf8Lead2    = 8'hc0;
    localparam logic [7:0]  Utf8Lead3    = 8'he0;
    localparam logic [7:0]  Utf8Cont     = 8'h80;

    // One result: decoded byte and its kind
    typedef struct packed {
        logic [7:0]  data;
        jsu_status_t status;
    } jsu_result_t;

    // Results caused by one request, handed from decoder to emitter
    typedef struct packed {
        logic                          valid;
        logic [CountW-1:0]             count;
        jsu_result_t [MaxResults-1:0]  slot;
    } jsu_bundle_t;

    // Hex digit value: bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/jsu_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_decode
// Input register, scan state and one-pass decode of a byte into a bundle
// of up to four results.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         in_data,
    input  wire logic               in_last,
    input  wire logic               out_free,
    output jsu_pkg::jsu_bundle_t    bundle
);

    typedef enum logic [2:0] {
        MODE_OUT  = 3'd0,
        MODE_IN   = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX  = 3'd3,
        MODE_DROP = 3'd4
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;

    logic                                        err;
    logic [jsu_pkg::CountW-1:0]                  nb;
    jsu_pkg::jsu_result_t [jsu_pkg::MaxResults-1:0] res;
    logic [4:0]                                  hex;
    logic [15:0]                                 cp;
    logic [7:0]                                  b;
    logic                                        fire;

    assign b   = in_data_reg;
    assign hex = jsu_pkg::hex_digit(b);
    assign cp  = {acc_reg[11:0], hex[3:0]};

    // Decode one byte against the current mode
    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        err       = 1'b0;
        nb        = '0;
        res       = '0;
        unique case (mode_reg)
            MODE_IN: begin
                if (b == jsu_pkg::ChQuote) begin
                    res[0]    = '{data: 8'd0, status: jsu_pkg::ST_CLOSED};
                    nb        = jsu_pkg::CountW'(1);
                    mode_next = MODE_OUT;
                end else if (b < jsu_pkg::ChCtrlLimit) begin
                    res[0] = '{data: 8'd0, status: jsu_pkg::ST_CTRL};
                    nb     = jsu_pkg::CountW'(1);
                    err    = 1'b1;
                end else if (b == jsu_pkg::ChBackslash) begin
                    mode_next = MODE_ESC;
                end else begin
                    res[0] = '{data: b, status: jsu_pkg::ST_BYTE};
                    nb     = jsu_pkg::CountW'(1);
                end
            end
            MODE_ESC: begin
                nb        = jsu_pkg::CountW'(1);
                mode_next = MODE_IN;
                unique case (b)
                    jsu_pkg::ChQuote, jsu_pkg::ChBackslash, jsu_pkg::ChSlash:
                        res[0] = '{data: b, status: jsu_pkg::ST_BYTE};
                    8'h62: res[0] = '{data: 8'h08, status: jsu_pkg::ST_BYTE};
                    8'h66: res[0] = '{data: 8'h0c, status: jsu_pkg::ST_BYTE};
                    8'h6e: res[0] = '{data: 8'h0a, status: jsu_pkg::ST_BYTE};
                    8'h72: res[0] = '{data: 8'h0d, status: jsu_pkg::ST_BYTE};
                    8'h74: res[0] = '{data: 8'h09, status: jsu_pkg::ST_BYTE};
                    8'h75: begin
                        nb        = '0;
                        acc_next  = 16'd0;
                        cnt_next  = 2'd0;
                        mode_next = MODE_HEX;
                    end
                    default: begin
                        res[0] = '{data: 8'd0, status: jsu_pkg::ST_BADESC};
                        err    = 1'b1;
                    end
                endcase
            end
            MODE_HEX: begin
                if (!hex[4]) begin
                    res[0] = '{data: 8'd0, status: jsu_pkg::ST_BADHEX};
                    nb     = jsu_pkg::CountW'(1);
                    err    = 1'b1;
                end else begin
                    acc_next = cp;
                    if (cnt_reg == 2'd3) begin
                        cnt_next  = 2'd0;
                        mode_next = MODE_IN;
                        // Encode the code point as UTF-8
                        if (cp <= jsu_pkg::CpOneByteMax) begin
                            res[0] = '{data: cp[7:0], status: jsu_pkg::ST_BYTE};
                            nb     = jsu_pkg::CountW'(1);
                        end else if (cp <= jsu_pkg::CpTwoByteMax) begin
                            res[0] = '{data: jsu_pkg::Utf8Lead2 | {3'd0, cp[10:6]},
                                       status: jsu_pkg::ST_BYTE};
                            res[1] = '{data: jsu_pkg::Utf8Cont | {2'd0, cp[5:0]},
                                       status: jsu_pkg::ST_BYTE};
                            nb     = jsu_pkg::CountW'(2);
                        end else begin
                            res[0] = '{data: jsu_pkg::Utf8Lead3 | {4'd0, cp[15:12]},
                                       status: jsu_pkg::ST_BYTE};
                            res[1] = '{data: jsu_pkg::Utf8Cont | {2'd0, cp[11:6]},
                                       status: jsu_pkg::ST_BYTE};
                            res[2] = '{data: jsu_pkg::Utf8Cont | {2'd0, cp[5:0]},
                                       status: jsu_pkg::ST_BYTE};
                            nb     = jsu_pkg::CountW'(3);
                        end
                    end else begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
            end
            MODE_DROP: begin
                mode_next = MODE_DROP;
            end
            default: begin
                mode_next = (b == jsu_pkg::ChQuote) ? MODE_IN : MODE_OUT;
            end
        endcase

        if (err) begin
            mode_next = MODE_DROP;
        end

        // Close out the buffer on its final byte
        if (in_last_reg) begin
            if (mode_next == MODE_IN || mode_next == MODE_ESC || mode_next == MODE_HEX) begin
                res[nb[jsu_pkg::SlotIdxW-1:0]] = '{data: 8'd0, status: jsu_pkg::ST_UNTERM};
                nb = nb + jsu_pkg::CountW'(1);
            end
            mode_next = MODE_OUT;
            cnt_next  = 2'd0;
        end
    end

    // Retire the held request once its results have room
    assign fire     = in_valid_reg && (nb == '0 || out_free);
    assign in_ready = !in_valid_reg || fire;

    assign bundle.valid = fire && (nb != '0);
    assign bundle.count = nb;
    assign bundle.slot  = res;

    // Hold scan state and the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_OUT;
            acc_reg      <= 16'd0;
            cnt_reg      <= 2'd0;
            in_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                cnt_reg  <= cnt_next;
            end
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
        end
        if (in_ready) begin
            in_data_reg <= in_data;
            in_last_reg <= in_last;
        end
    end

endmodule
`default_nettype wire

FILE: sv/jsu_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_emit
// Result register that holds one bundle and hands its results out one per
// cycle on the result channel while m_tready is high.
// ----------------------------------------------------------------------------
module jsu_emit (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire jsu_pkg::jsu_bundle_t bundle,
    output logic                      out_free,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,
    output logic [2:0]                m_tuser,
    output logic                      m_tlast
);

    jsu_pkg::jsu_bundle_t              bundle_reg;
    logic [jsu_pkg::SlotIdxW-1:0]      idx_reg;
    logic [jsu_pkg::CountW-1:0]        last_idx;
    logic                              at_last;
    jsu_pkg::jsu_result_t              cur;

    assign last_idx = bundle_reg.count - jsu_pkg::CountW'(1);
    assign at_last  = ({1'b0, idx_reg} == last_idx);
    assign cur      = bundle_reg.slot[idx_reg];

    assign out_free = !bundle_reg.valid || (m_tready && at_last);

    assign m_tvalid = bundle_reg.valid;
    assign m_tdata  = cur.data;
    assign m_tuser  = cur.status;
    assign m_tlast  = at_last;

    // Load a new bundle or advance through the held one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bundle_reg.valid <= 1'b0;
            idx_reg          <= '0;
        end else if (bundle.valid) begin
            bundle_reg.valid <= 1'b1;
            idx_reg          <= '0;
        end else if (bundle_reg.valid && m_tready) begin
            if (at_last) begin
                bundle_reg.valid <= 1'b0;
            end else begin
                idx_reg <= idx_reg + jsu_pkg::SlotIdxW'(1);
            end
        end
        if (bundle.valid) begin
            bundle_reg.count <= bundle.count;
            bundle_reg.slot  <= bundle.slot;
        end
    end

endmodule
`default_nettype wire

FILE: sv/json_string_unescape_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_unit
// Byte-stream decoder for JSON quoted strings with escape and UTF-8 output.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_): one raw text byte per request in s_tdata, s_tlast
//   marks the final byte of a buffer. Bytes outside quotes are skipped.
//   Result stream (m_): m_tdata carries a decoded byte, m_tuser its kind
//   (byte, string closed, control char, bad escape, bad hex, unterminated),
//   m_tlast marks the final result caused by one input byte.
//   A request passes through the input register, then the result register.
//   A byte with zero or one result is taken every cycle while m_tready
//   is high; a byte that gives N results (UTF-8 of an escape, plus an
//   unterminated flag) holds the input while the result register hands
//   them out one per cycle while m_tready is high.
//   A new byte is accepted while the last result of the previous byte is
//   still waiting on m_tready. When the receiver stalls, the result register
//   holds, then the input register fills and s_tready drops.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   scanner to outside-string with no hex digits gathered.
// ----------------------------------------------------------------------------
module json_string_unescape_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [2:0]      m_tuser,   // [2:0] status
    output logic            m_tlast
);

    jsu_pkg::jsu_bundle_t bundle;
    logic                 out_free;

    jsu_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .in_last  (s_tlast),
        .out_free (out_free),
        .bundle   (bundle)
    );

    jsu_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .bundle   (bundle),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

FILE: sv/jsu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the result stream of the unescape unit.
// ----------------------------------------------------------------------------
module jsu_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [2:0] m_tuser,
    input wire logic       m_tlast
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Reset empties the input register, so a request can be taken at once
    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // Non-byte results carry zero data
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != jsu_pkg::ST_BYTE |-> m_tdata == 8'd0)
        else $error("data not zero on non-byte result");

    // Closes and errors always end the run for their byte
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != jsu_pkg::ST_BYTE |-> m_tlast)
        else $error("status result not last of run");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (.*);
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for json_string_unescape_unit. Raw text bytes go in on
// the s_ stream with random gaps and the m_ stream is back-pressured at random.
// A scoreboard decodes each accepted request on its own and compares every
// result (byte, kind, end-of-run flag) in order against what it predicted.
// ----------------------------------------------------------------------------
module tb;

    localparam int CyclesLimit = 400000;
    localparam int TargetBytes = 260;
    localparam int DrainCycles = 8;
    localparam int MaxReported = 40;

    typedef enum logic [2:0] {
        SCAN_OUT,
        SCAN_IN,
        SCAN_ESC,
        SCAN_HEX,
        SCAN_DROP
    } scan_mode_t;

    typedef struct {
        logic [7:0]           data;
        jsu_pkg::jsu_status_t kind;
        logic                 fin;
    } decoded_t;

    typedef struct {
        logic [7:0] b;
        logic       l;
    } raw_byte_t;

    // Escape letters that map to a single byte
    localparam logic [7:0] EscChars [8] = '{jsu_pkg::ChQuote, jsu_pkg::ChBackslash,
                                             jsu_pkg::ChSlash,
                                             "b", "f", "n", "r", "t"};

    // ------------------------------------------------------------------------
    // Decoder scoreboard: own copy of the scanner state and the results owed
    // ------------------------------------------------------------------------
    class unescape_scoreboard;
        scan_mode_t  mode;
        logic [15:0] accum;
        logic [1:0]  digits;
        decoded_t    fresh[$];
        decoded_t    pending[$];
        int          errors;
        int          bytes_noted;
        int          results_seen;
        int          strings_closed;
        int          unicode_escapes;

        function new();
            mode   = SCAN_OUT;
            accum  = '0;
            digits = '0;
        endfunction

        task report(input string what);
            if (errors < MaxReported) begin
                $display("tb: mismatch: %s", what);
            end
            errors++;
        endtask

        function void add(input logic [7:0] d, input jsu_pkg::jsu_status_t k);
            decoded_t r;
            r.data = (k == jsu_pkg::ST_BYTE) ? d : 8'h00;
            r.kind = k;
            r.fin  = 1'b0;
            fresh.push_back(r);
        endfunction

        // Encode the gathered code point as UTF-8, surrogates as they stand
        function void add_utf8();
            unicode_escapes++;
            if (accum <= jsu_pkg::CpOneByteMax) begin
                add(accum[7:0], jsu_pkg::ST_BYTE);
            end else if (accum <= jsu_pkg::CpTwoByteMax) begin
                add(jsu_pkg::Utf8Lead2 | {3'd0, accum[10:6]}, jsu_pkg::ST_BYTE);
                add(jsu_pkg::Utf8Cont | {2'd0, accum[5:0]}, jsu_pkg::ST_BYTE);
            end else begin
                add(jsu_pkg::Utf8Lead3 | {4'd0, accum[15:12]}, jsu_pkg::ST_BYTE);
                add(jsu_pkg::Utf8Cont | {2'd0, accum[11:6]}, jsu_pkg::ST_BYTE);
                add(jsu_pkg::Utf8Cont | {2'd0, accum[5:0]}, jsu_pkg::ST_BYTE);
            end
        endfunction

        // Advance the scanner by one accepted request and queue its results
        function void note_byte(input logic [7:0] b, input logic l);
            bit         err;
            bit         is_hex;
            logic [3:0] nib;
            err    = 1'b0;
            is_hex = 1'b1;
            nib    = '0;
            bytes_noted++;
            case (mode)
                SCAN_IN: begin
                    if (b == jsu_pkg::ChQuote) begin
                        add(8'h00, jsu_pkg::ST_CLOSED);
                        strings_closed++;
                        mode = SCAN_OUT;
                    end else if (b < jsu_pkg::ChCtrlLimit) begin
                        add(8'h00, jsu_pkg::ST_CTRL);
                        err = 1'b1;
                    end else if (b == jsu_pkg::ChBackslash) begin
                        mode = SCAN_ESC;
                    end else begin
                        add(b, jsu_pkg::ST_BYTE);
                    end
                end
                SCAN_ESC: begin
                    mode = SCAN_IN;
                    case (b)
                        jsu_pkg::ChQuote, jsu_pkg::ChBackslash, jsu_pkg::ChSlash:
                            add(b, jsu_pkg::ST_BYTE);
                        "b": add(8'h08, jsu_pkg::ST_BYTE);
                        "f": add(8'h0c, jsu_pkg::ST_BYTE);
                        "n": add(8'h0a, jsu_pkg::ST_BYTE);
                        "r": add(8'h0d, jsu_pkg::ST_BYTE);
                        "t": add(8'h09, jsu_pkg::ST_BYTE);
                        "u": begin
                            accum  = '0;
                            digits = '0;
                            mode   = SCAN_HEX;
                        end
                        default: begin
                            add(8'h00, jsu_pkg::ST_BADESC);
                            err = 1'b1;
                        end
                    endcase
                end
                SCAN_HEX: begin
                    if (b inside {["0":"9"]}) begin
                        nib = 4'(b - "0");
                    end else if (b inside {["a":"f"]}) begin
                        nib = 4'(b - "a" + 10);
                    end else if (b inside {["A":"F"]}) begin
                        nib = 4'(b - "A" + 10);
                    end else begin
                        is_hex = 1'b0;
                    end
                    if (!is_hex) begin
                        add(8'h00, jsu_pkg::ST_BADHEX);
                        err = 1'b1;
                    end else begin
                        accum = {accum[11:0], nib};
                        if (digits == 2'd3) begin
                            digits = '0;
                            add_utf8();
                            mode = SCAN_IN;
                        end else begin
                            digits = digits + 2'd1;
                        end
                    end
                end
                SCAN_DROP: ;
                default: mode = (b == jsu_pkg::ChQuote) ? SCAN_IN : SCAN_OUT;
            endcase

            if (err) mode = SCAN_DROP;

            // End of buffer: flag a string left open, then return outside
            if (l) begin
                if (mode == SCAN_IN || mode == SCAN_ESC || mode == SCAN_HEX) begin
                    add(8'h00, jsu_pkg::ST_UNTERM);
                end
                mode   = SCAN_OUT;
                digits = '0;
            end

            if (fresh.size() > 0) fresh[fresh.size() - 1].fin = 1'b1;
            foreach (fresh[i]) pending.push_back(fresh[i]);
            fresh.delete();
        endfunction

        // Compare one accepted result with the oldest one owed
        task check_result(input logic [7:0] d, input logic [2:0] k, input logic f);
            decoded_t e;
            results_seen++;
            if (pending.size() == 0) begin
                report($sformatf("result %0d (data %02h kind %0d) with nothing owed",
                                 results_seen, d, k));
                return;
            end
            e = pending.pop_front();
            if (d !== e.data) begin
                report($sformatf("result %0d data %02h, want %02h",
                                 results_seen, d, e.data));
            end
            if (k !== e.kind) begin
                report($sformatf("result %0d kind %0d, want %s",
                                 results_seen, k, e.kind.name()));
            end
            if (f !== e.fin) begin
                report($sformatf("result %0d tlast %b, want %b",
                                 results_seen, f, e.fin));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    always #5 aclk = ~aclk;

    json_string_unescape_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    unescape_scoreboard sb = new();

    int        cycles     = 0;
    int        stall_left = 0;
    int        live_bytes = 0;
    bit        calm       = 1'b0;
    raw_byte_t plan[$];

    // Mostly short gaps, a few long ones; none during a calm stretch
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Hard stop on a hung run
    always @(posedge aclk) begin
        cycles++;
        if (cycles == CyclesLimit) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Result side: check each accepted result, then stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser, m_tlast);
        end
        if ($urandom_range(0, 199) == 0) calm <= !calm;
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Text builders
    // ------------------------------------------------------------------------
    function automatic void queue_byte(input logic [7:0] b, input logic l = 1'b0);
        raw_byte_t r;
        r.b = b;
        r.l = l;
        plan.push_back(r);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic upper;
        upper = 1'($urandom_range(0, 1));
        if (n < 4'd10) return "0" + n;
        return (upper ? "A" : "a") + n - 8'd10;
    endfunction

    function automatic void queue_unicode();
        logic [15:0] cp;
        case ($urandom_range(0, 2))
            0:       cp = 16'($urandom_range(0, 16'h007f));
            1:       cp = 16'($urandom_range(16'h0080, 16'h07ff));
            default: cp = 16'($urandom_range(16'h0800, 16'hffff));
        endcase
        queue_byte(jsu_pkg::ChBackslash);
        queue_byte("u");
        queue_byte(hex_char(cp[15:12]));
        queue_byte(hex_char(cp[11:8]));
        queue_byte(hex_char(cp[7:4]));
        queue_byte(hex_char(cp[3:0]));
    endfunction

    // One malformed piece: control byte, bad escape letter or bad hex digit
    function automatic void queue_fault();
        logic [7:0] c;
        int         k;
        case ($urandom_range(0, 2))
            0: queue_byte(8'($urandom_range(0, 8'h1f)));
            1: begin
                do c = 8'($urandom_range(0, 255));
                while (c inside {jsu_pkg::ChQuote, jsu_pkg::ChBackslash, jsu_pkg::ChSlash,
                                 "b", "f", "n", "r", "t", "u"});
                queue_byte(jsu_pkg::ChBackslash);
                queue_byte(c);
            end
            default: begin
                k = $urandom_range(0, 3);
                queue_byte(jsu_pkg::ChBackslash);
                queue_byte("u");
                repeat (k) queue_byte(hex_char(4'($urandom_range(0, 15))));
                do c = 8'($urandom_range(0, 255));
                while (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
                queue_byte(c);
            end
        endcase
    endfunction

    // A quoted string with random content: mostly closed, some cut short,
    // some broken and then dropped up to a last byte
    function automatic void queue_string();
        int         tokens;
        int         r;
        bit         broken;
        bit         ragged;
        logic [7:0] c;
        tokens = $urandom_range(0, 8);
        broken = ($urandom_range(0, 4) == 0);
        ragged = !broken && ($urandom_range(0, 4) == 0);
        queue_byte(jsu_pkg::ChQuote);
        repeat (tokens) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                do c = 8'($urandom_range(8'h20, 8'hff));
                while (c == jsu_pkg::ChQuote || c == jsu_pkg::ChBackslash);
                queue_byte(c);
            end else if (r < 75) begin
                queue_byte(jsu_pkg::ChBackslash);
                queue_byte(EscChars[$urandom_range(0, 7)]);
            end else begin
                queue_unicode();
            end
        end
        if (broken) begin
            queue_fault();
            if ($urandom_range(0, 3) == 0) begin
                plan[plan.size() - 1].l = 1'b1;
            end else begin
                repeat ($urandom_range(0, 3)) queue_byte(8'($urandom_range(0, 255)));
                queue_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        end else if (ragged) begin
            case ($urandom_range(0, 2))
                0: ;
                1: queue_byte(jsu_pkg::ChBackslash);
                default: begin
                    queue_byte(jsu_pkg::ChBackslash);
                    queue_byte("u");
                    repeat ($urandom_range(0, 3)) queue_byte(hex_char(4'($urandom_range(0, 15))));
                end
            endcase
            plan[plan.size() - 1].l = 1'b1;
        end else begin
            queue_byte(jsu_pkg::ChQuote, 1'($urandom_range(0, 5) == 0));
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offer one request after a random gap and hold it until accepted.
    // Handshake signals are read just after the edge, before any update.
    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b, l);
    endtask

    task automatic send_plan();
        foreach (plan[i]) send_byte(plan[i].b, plan[i].l);
        plan.delete();
    endtask

    initial begin
        logic [7:0] c;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: skipped byte, open, top byte, \u0000, three- and
        // two-byte UTF-8, control char then drop to a last byte, an opening
        // quote on a last byte, a bad hex digit on a last byte
        queue_byte("k");
        queue_byte(jsu_pkg::ChQuote);
        queue_byte(8'hff);
        queue_byte(jsu_pkg::ChBackslash); queue_byte("u");
        queue_byte("0"); queue_byte("0"); queue_byte("0"); queue_byte("0");
        queue_byte(jsu_pkg::ChBackslash); queue_byte("u");
        queue_byte("F"); queue_byte("f"); queue_byte("f"); queue_byte("F");
        queue_byte(jsu_pkg::ChBackslash); queue_byte("u");
        queue_byte("0"); queue_byte("7"); queue_byte("f"); queue_byte("F");
        queue_byte(8'h1f);
        queue_byte("x", 1'b1);
        queue_byte(jsu_pkg::ChQuote, 1'b1);
        queue_byte(jsu_pkg::ChQuote); queue_byte(jsu_pkg::ChBackslash); queue_byte("u");
        queue_byte("g", 1'b1);
        live_bytes += plan.size();
        send_plan();

        // Random strings with a little noise between them
        while (live_bytes < TargetBytes) begin
            repeat ($urandom_range(0, 2)) begin
                do c = 8'($urandom_range(0, 255)); while (c == jsu_pkg::ChQuote);
                send_byte(c, 1'($urandom_range(0, 7) == 0));
                live_bytes++;
            end
            queue_string();
            live_bytes += plan.size();
            send_plan();
        end
        s_tvalid <= 1'b0;

        // Drain what is owed, then watch for strays
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        $display("tb: %0d bytes accepted, %0d results checked",
                 sb.bytes_noted, sb.results_seen);
        $display("tb: %0d strings closed, %0d unicode escapes decoded",
                 sb.strings_closed, sb.unicode_escapes);
        if (sb.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
